// ===== design/chtb_pkg.sv =====
// Shared types and constants for the cyclic handler timer bank.
package chtb_pkg;
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int MAX_RES = 8;

  localparam logic [2:0] K_CREATE = 3'd0;
  localparam logic [2:0] K_START  = 3'd1;
  localparam logic [2:0] K_STOP   = 3'd2;
  localparam logic [2:0] K_DELETE = 3'd3;
  localparam logic [2:0] K_REFER  = 3'd4;
  localparam logic [2:0] K_TICK   = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_CTX   = 3'd1;
  localparam logic [2:0] ST_PAR   = 3'd2;
  localparam logic [2:0] ST_RSATR = 3'd3;
  localparam logic [2:0] ST_LIMIT = 3'd4;
  localparam logic [2:0] ST_ID    = 3'd5;

  localparam logic [15:0] TICK_STEP_RESET = 16'd10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot_id;
    logic        from_interrupt;
    logic        has_handler;
    logic [31:0] period;
    logic [31:0] phase;
    logic [2:0]  attributes;
    logic [31:0] handler_tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  new_id;
    logic        running;
    logic [30:0] left_time;
    logic        fired;
    logic [3:0]  fired_id;
    logic [31:0] fired_tag;
    logic        last;
  } rsp_t;
endpackage

// ===== design/chtb_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
interface chtb_req_if;
  import chtb_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface chtb_rsp_if;
  import chtb_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface chtb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/cyclic_handler_timer_bank.sv =====
// Cyclic handler timer bank: top level with slot store and tick sequencer.
// A non-tick request is checked in S_EXEC, which loads its result into the output register.
// A tick starts in S_EXEC and finishes in S_DONE. Each slot is scanned in S_SCAN,
// and a firing slot adds 16 modulo steps in S_DIV and a write-back in S_FIRE.
// Throughput: one request at a time; the next one is taken once the last result drains.
// Reset (rst, synchronous): all slots free and stopped, tick_step = 10.
module cyclic_handler_timer_bank (
  input logic clk,
  input logic rst,
  chtb_req_if.sink req,
  chtb_rsp_if.source rsp,
  chtb_cfg_if.sink cfg
);
  import chtb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIRE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  req_t r;
  logic [15:0] tick_step;
  logic [NUM_SLOTS-1:0] slot_exists, slot_active;
  logic [30:0] slot_period [NUM_SLOTS];
  logic [30:0] slot_phase [NUM_SLOTS];
  logic [31:0] slot_tag [NUM_SLOTS];
  logic [30:0] slot_remaining [NUM_SLOTS];

  logic [SLOT_W-1:0] idx;
  logic [SLOT_W:0] nfire;
  logic pend_valid;
  rsp_t pend;
  logic [15:0] over;
  logic [30:0] modr;
  logic [3:0] bitn;
  logic [30:0] per;

  function automatic rsp_t mk(input logic [2:0] st);
    rsp_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    return o;
  endfunction

  logic [SLOT_W-1:0] free_idx;
  logic free_found;
  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_exists[i]) begin
        free_idx = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  logic [SLOT_W-1:0] sid;
  logic id_ok;
  assign sid = SLOT_W'(r.slot_id - 4'd1);
  assign id_ok = (r.slot_id >= 4'd1) && ({1'b0, r.slot_id} <= 5'(NUM_SLOTS));

  logic create_ok, op_ok;
  assign create_ok = (r.kind == K_CREATE) && !r.from_interrupt && r.has_handler &&
                     (r.period != 32'd0) && !r.period[31] && !r.phase[31] &&
                     !r.attributes[2] && free_found;
  assign op_ok = (r.kind != K_CREATE) && (r.kind < K_TICK) && !r.from_interrupt &&
                 id_ok && slot_exists[sid];

  rsp_t exec_rsp;
  always_comb begin
    exec_rsp = mk(ST_OK);
    if (r.kind == K_CREATE) begin
      if (r.from_interrupt) exec_rsp = mk(ST_CTX);
      else if (!r.has_handler || r.period == 32'd0 || r.period[31] || r.phase[31])
        exec_rsp = mk(ST_PAR);
      else if (r.attributes[2]) exec_rsp = mk(ST_RSATR);
      else if (!free_found) exec_rsp = mk(ST_LIMIT);
      else exec_rsp.new_id = 4'({1'b0, free_idx} + 1'b1);
    end else if (r.kind > K_TICK) exec_rsp = mk(ST_PAR);
    else if (r.from_interrupt) exec_rsp = mk(ST_CTX);
    else if (!id_ok || !slot_exists[sid]) exec_rsp = mk(ST_ID);
    else if (r.kind == K_REFER) begin
      exec_rsp.running = slot_active[sid];
      exec_rsp.left_time = slot_active[sid] ? slot_remaining[sid] : 31'd0;
    end
  end

  logic [31:0] trial;
  assign trial = {modr, over[4'd15 - bitn]} - {1'b0, per};

  logic [30:0] rem;
  assign rem = slot_remaining[idx];
  logic last_slot;
  assign last_slot = (idx == SLOT_W'(NUM_SLOTS - 1));

  logic report;
  assign report = (nfire < (SLOT_W+1)'(MAX_RES));

  rsp_t fire_rsp;
  always_comb begin
    fire_rsp = '0;
    fire_rsp.fired = 1'b1;
    fire_rsp.fired_id = 4'({1'b0, idx} + 1'b1);
    fire_rsp.fired_tag = slot_tag[idx];
  end

  rsp_t done_rsp;
  always_comb begin
    done_rsp = mk(ST_OK);
    if (pend_valid) begin
      done_rsp = pend;
      done_rsp.last = 1'b1;
    end
  end

  logic rsp_free;
  assign rsp_free = !rsp.valid || rsp.ready;

  logic out_load;
  assign out_load = ((state == S_EXEC) && (r.kind != K_TICK)) ||
                    ((state == S_FIRE) && report && pend_valid && rsp_free) ||
                    ((state == S_DONE) && rsp_free);

  assign req.ready = (state == S_IDLE) && !rsp.valid;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick_step <= TICK_STEP_RESET;
      slot_exists <= '0;
      slot_active <= '0;
      rsp.valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg.valid) tick_step <= cfg.data;
      if (out_load) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            r <= req.data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (r.kind == K_TICK) begin
            idx <= '0;
            nfire <= '0;
            pend_valid <= 1'b0;
            state <= S_SCAN;
          end else begin
            rsp.data <= exec_rsp;
            state <= S_IDLE;
            if (create_ok) begin
              slot_period[free_idx] <= r.period[30:0];
              slot_phase[free_idx] <= r.phase[30:0];
              slot_tag[free_idx] <= r.handler_tag;
              slot_remaining[free_idx] <= r.phase[30:0];
              slot_active[free_idx] <= r.attributes[1];
              slot_exists[free_idx] <= 1'b1;
            end else if (op_ok) begin
              unique case (r.kind)
                K_START: begin
                  slot_remaining[sid] <= slot_phase[sid];
                  slot_active[sid] <= 1'b1;
                end
                K_STOP: slot_active[sid] <= 1'b0;
                K_DELETE: begin
                  slot_active[sid] <= 1'b0;
                  slot_exists[sid] <= 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (!slot_exists[idx] || !slot_active[idx]) begin
            if (last_slot) state <= S_DONE;
            else idx <= idx + 1'b1;
          end else if ({1'b0, rem} > {16'd0, tick_step}) begin
            slot_remaining[idx] <= rem - {15'd0, tick_step};
            if (last_slot) state <= S_DONE;
            else idx <= idx + 1'b1;
          end else begin
            over <= tick_step - rem[15:0];
            per <= slot_period[idx];
            modr <= '0;
            bitn <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          modr <= trial[31] ? {modr[29:0], over[4'd15 - bitn]} : trial[30:0];
          bitn <= bitn + 4'd1;
          if (bitn == 4'd15) state <= S_FIRE;
        end
        S_FIRE: begin
          if (!report || !pend_valid || rsp_free) begin
            slot_remaining[idx] <= per - modr;
            if (report) begin
              nfire <= nfire + 1'b1;
              if (pend_valid) rsp.data <= pend;
              pend <= fire_rsp;
              pend_valid <= 1'b1;
            end
            if (last_slot) state <= S_DONE;
            else begin
              idx <= idx + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        default: begin
          if (rsp_free) begin
            rsp.data <= done_rsp;
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// ===== test/chtb_checker.sv =====
// Checker for the cyclic handler timer bank: predicts results and compares transfers.
`timescale 1ns / 1ps
module chtb_checker
  import chtb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  chtb_req_if        req,
  chtb_rsp_if        rsp,
  chtb_cfg_if        cfg,
  output int         errors,
  output int         pending
);
  localparam logic [30:0] M31 = 31'h7FFF_FFFF;

  logic [15:0] step_now;
  logic        live[NUM_SLOTS];
  logic        armed[NUM_SLOTS];
  logic [30:0] period_of[NUM_SLOTS];
  logic [30:0] phase_of[NUM_SLOTS];
  logic [31:0] tag_of[NUM_SLOTS];
  logic [31:0] left_of[NUM_SLOTS];
  rsp_t        expected_q[$];

  assign pending = expected_q.size();

  function automatic rsp_t status_only(logic [2:0] st);
    rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void run_tick();
    rsp_t        r;
    int          n;
    logic [31:0] over;
    logic [31:0] per;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (live[i] && armed[i]) begin
        if (left_of[i] > {16'd0, step_now}) begin
          left_of[i] = left_of[i] - {16'd0, step_now};
        end else begin
          over = {16'd0, step_now} - left_of[i];
          per = {1'b0, period_of[i]};
          if (per == 0) per = 1;
          left_of[i] = {1'b0, 31'((per - (over % per)) & {1'b0, M31})};
          if (n < MAX_RES) begin
            r = '0;
            r.fired = 1'b1;
            r.fired_id = 4'(i + 1);
            r.fired_tag = tag_of[i];
            expected_q.push_back(r);
            n++;
          end
        end
      end
    end
    if (n == 0) begin
      expected_q.push_back(status_only(ST_OK));
    end else begin
      r = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.push_back(r);
    end
  endfunction

  function automatic void predict_request(req_t q);
    rsp_t r;
    int   s;
    bit   done;
    if (q.kind == K_TICK) begin
      run_tick();
    end else if (q.kind == K_CREATE) begin
      if (q.from_interrupt) begin
        expected_q.push_back(status_only(ST_CTX));
      end else if (!q.has_handler || q.period == 0 || q.period[31] || q.phase[31]) begin
        expected_q.push_back(status_only(ST_PAR));
      end else if (q.attributes[2]) begin
        expected_q.push_back(status_only(ST_RSATR));
      end else begin
        done = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!done && !live[i]) begin
            period_of[i] = q.period[30:0];
            phase_of[i] = q.phase[30:0];
            tag_of[i] = q.handler_tag;
            left_of[i] = {1'b0, q.phase[30:0]};
            armed[i] = q.attributes[1];
            live[i] = 1'b1;
            r = status_only(ST_OK);
            r.new_id = 4'(i + 1);
            expected_q.push_back(r);
            done = 1;
          end
        end
        if (!done) expected_q.push_back(status_only(ST_LIMIT));
      end
    end else if (q.kind > K_TICK) begin
      expected_q.push_back(status_only(ST_PAR));
    end else if (q.from_interrupt) begin
      expected_q.push_back(status_only(ST_CTX));
    end else if (q.slot_id < 1 || q.slot_id > NUM_SLOTS || !live[q.slot_id - 1]) begin
      expected_q.push_back(status_only(ST_ID));
    end else begin
      s = q.slot_id - 1;
      r = status_only(ST_OK);
      case (q.kind)
        K_START: begin
          left_of[s] = {1'b0, phase_of[s]};
          armed[s] = 1'b1;
        end
        K_STOP: armed[s] = 1'b0;
        K_DELETE: begin
          armed[s] = 1'b0;
          live[s] = 1'b0;
        end
        default: begin
          r.running = armed[s];
          r.left_time = armed[s] ? left_of[s][30:0] : 31'd0;
        end
      endcase
      expected_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      step_now = TICK_STEP_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        live[i] = 1'b0;
        armed[i] = 1'b0;
      end
      expected_q.delete();
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp.data);
          errors++;
        end else begin
          if (rsp.data !== expected_q[0]) begin
            $display("%0t: result mismatch, expected %p, actual %p",
                     $time, expected_q[0], rsp.data);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
      if (cfg.valid && cfg.ready) step_now = cfg.data;
      if (req.valid && req.ready) predict_request(req.data);
    end
  end
endmodule

// ===== test/tb_cyclic_handler_timer_bank.sv =====
// Top testbench for the cyclic handler timer bank: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_cyclic_handler_timer_bank;
  import chtb_pkg::*;

  localparam logic [2:0] K_UNDEF_LO = 3'd6;
  localparam logic [2:0] K_UNDEF_HI = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 0;
  logic rst = 1;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   stall_left = 0;

  chtb_req_if req_ch();
  chtb_rsp_if rsp_ch();
  chtb_cfg_if cfg_ch();

  cyclic_handler_timer_bank u_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  chtb_checker u_checker (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 9) < 3) begin
      rsp_ch.ready = 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(req_t r);
    int gap;
    req_ch.data = r;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_step(logic [15:0] v);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_ch.data = v;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic req_t mk_create(bit intr, bit hdr, logic [31:0] per, logic [31:0] phs,
                                     logic [2:0] atr, logic [31:0] tag);
    req_t r;
    r = '0;
    r.kind = K_CREATE;
    r.slot_id = 4'($urandom_range(0, 15));
    r.from_interrupt = intr;
    r.has_handler = hdr;
    r.period = per;
    r.phase = phs;
    r.attributes = atr;
    r.handler_tag = tag;
    return r;
  endfunction

  function automatic req_t mk_op(logic [2:0] k, logic [3:0] id, bit intr);
    req_t r;
    r = '0;
    r.kind = k;
    r.slot_id = id;
    r.from_interrupt = intr;
    return r;
  endfunction

  function automatic req_t random_request();
    int          p;
    logic [31:0] per;
    logic [31:0] phs;
    logic [3:0]  id;
    p = $urandom_range(0, 99);
    per = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 300);
    phs = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300);
    id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    if (p < 38) return mk_op(K_TICK, 4'($urandom()), 1'($urandom_range(0, 1)));
    if (p < 58)
      return mk_create($urandom_range(0, 19) == 0, $urandom_range(0, 19) != 0, per, phs,
                       ($urandom_range(0, 9) == 0) ? 3'($urandom()) : 3'($urandom_range(0, 3)),
                       $urandom());
    if (p < 70) return mk_op(K_START, id, $urandom_range(0, 19) == 0);
    if (p < 78) return mk_op(K_STOP, id, $urandom_range(0, 19) == 0);
    if (p < 85) return mk_op(K_DELETE, id, $urandom_range(0, 19) == 0);
    if (p < 98) return mk_op(K_REFER, id, $urandom_range(0, 19) == 0);
    return mk_op($urandom_range(0, 1) ? K_UNDEF_LO : K_UNDEF_HI, id, 1'b0);
  endfunction

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: parameter checks, fill and overflow, id checks, ticks
    send_request(mk_create(1'b1, 1'b1, 32'd5, 32'd0, 3'd0, 32'h0));
    send_request(mk_create(1'b0, 1'b0, 32'd5, 32'd0, 3'd0, 32'h0));
    send_request(mk_create(1'b0, 1'b1, 32'd0, 32'd0, 3'd0, 32'h0));
    send_request(mk_create(1'b0, 1'b1, 32'h8000_0000, 32'd0, 3'd0, 32'h0));
    send_request(mk_create(1'b0, 1'b1, 32'd5, 32'hFFFF_FFFF, 3'd0, 32'h0));
    send_request(mk_create(1'b0, 1'b1, 32'd5, 32'd0, 3'd4, 32'h0));
    send_request(mk_create(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd3, 32'hFFFF_FFFF));
    send_request(mk_create(1'b0, 1'b1, 32'd1, 32'd0, 3'd2, 32'hA5A5_5A5A));
    for (int i = 0; i < 6; i++)
      send_request(mk_create(1'b0, 1'b1, 32'd3 + i, 32'd5 * i, 3'd2, 32'h100 + i));
    send_request(mk_create(1'b0, 1'b1, 32'd7, 32'd7, 3'd2, 32'h0));
    send_request(mk_op(K_TICK, 4'd0, 1'b1));
    send_request(mk_op(K_REFER, 4'd1, 1'b0));
    send_request(mk_op(K_REFER, 4'd0, 1'b0));
    send_request(mk_op(K_STOP, 4'd9, 1'b0));
    send_request(mk_op(K_START, 4'd15, 1'b0));
    send_request(mk_op(K_STOP, 4'd2, 1'b1));
    send_request(mk_op(K_STOP, 4'd2, 1'b0));
    send_request(mk_op(K_REFER, 4'd2, 1'b0));
    send_request(mk_op(K_DELETE, 4'd8, 1'b0));
    send_request(mk_op(K_START, 4'd8, 1'b0));
    send_request(mk_op(K_UNDEF_LO, 4'd1, 1'b0));
    send_request(mk_op(K_UNDEF_HI, 4'd1, 1'b1));

    write_step(16'd65535);
    send_request(mk_op(K_TICK, 4'd0, 1'b0));
    send_request(mk_op(K_REFER, 4'd1, 1'b0));
    write_step(16'd0);
    send_request(mk_op(K_TICK, 4'd0, 1'b0));
    send_request(mk_op(K_TICK, 4'd0, 1'b0));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_step(16'd1);
        1: write_step(16'($urandom_range(2, 60)));
        default: write_step(16'($urandom_range(61, 65535)));
      endcase
      for (int i = 0; i < 26; i++) send_request(random_request());
    end

    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
